[src/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent, outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/lupc_pkg.sv]
// types and constants for the lru unprotected page cache
package lupc_pkg;

  localparam int PAGE_BITS = 36;
  localparam int EXT_BITS  = 64;

  localparam logic CMD_TOUCH = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef enum logic [1:0] {
    ACT_HIT       = 2'd0,
    ACT_UNPROTECT = 2'd1,
    ACT_PROTECT   = 2'd2,
    ACT_CLEAR     = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TOUCH,
    ST_EVICT,
    ST_FLUSH
  } state_t;

  typedef enum logic [1:0] {
    DP_NONE,
    DP_TOUCH,
    DP_EVICT,
    DP_FLUSH_STEP
  } dp_op_t;

  typedef struct packed {
    logic   capture;
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic hit;
    logic full;
    logic front_valid;
  } dp_status_t;

endpackage

[src/lupc_datapath.sv]
// page list, tag compare, move-to-front shifter and result register
module lupc_datapath #(
  parameter int ENTRIES    = 10,
  parameter int ADDR_BITS  = 48,
  parameter int PAGE_SHIFT = 12
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [ADDR_BITS-1:0]           in_address,
  input  lupc_pkg::dp_cmd_t              cmd,
  output lupc_pkg::dp_status_t           status,
  output logic                           out_valid,
  output logic [1:0]                     out_action,
  output logic [lupc_pkg::PAGE_BITS-1:0] out_page_number,
  output logic                           out_last
);

  localparam int PB = lupc_pkg::PAGE_BITS;

  logic [PB-1:0]              page_r   [ENTRIES];
  logic [PB-1:0]              page_nxt [ENTRIES];
  logic [ENTRIES-1:0]         valid_r, valid_nxt;
  logic [PB-1:0]              req_page_r, req_page_nxt;
  logic [PB-1:0]              evict_r, evict_nxt;
  logic                       out_valid_r, out_valid_nxt;
  lupc_pkg::action_t          out_action_r, out_action_nxt;
  logic [PB-1:0]              out_page_r, out_page_nxt;
  logic                       out_last_r, out_last_nxt;

  logic [lupc_pkg::EXT_BITS-1:0] addr_ext;
  logic [PB-1:0]                 in_page;
  logic [ENTRIES-1:0]            match;
  logic [ENTRIES-1:0]            move_mask;
  logic                          hit;

  assign addr_ext = lupc_pkg::EXT_BITS'(in_address);
  assign in_page  = addr_ext[PAGE_SHIFT +: PB];

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_r[i] && (page_r[i] == req_page_r);
    end
    hit = |match;
    for (int j = 0; j < ENTRIES; j++) begin
      move_mask[j] = hit ? ((match >> j) != '0) : 1'b1;
    end
  end

  assign status.hit         = hit;
  assign status.full        = valid_r[ENTRIES-1];
  assign status.front_valid = valid_r[0];

  always_comb begin
    page_nxt       = page_r;
    valid_nxt      = valid_r;
    evict_nxt      = evict_r;
    req_page_nxt   = cmd.capture ? in_page : req_page_r;
    out_valid_nxt  = 1'b0;
    out_action_nxt = out_action_r;
    out_page_nxt   = out_page_r;
    out_last_nxt   = out_last_r;
    unique case (cmd.op)
      lupc_pkg::DP_TOUCH: begin
        for (int j = 1; j < ENTRIES; j++) begin
          if (move_mask[j]) begin
            page_nxt[j]  = page_r[j-1];
            valid_nxt[j] = valid_r[j-1];
          end
        end
        page_nxt[0]   = req_page_r;
        valid_nxt[0]  = 1'b1;
        evict_nxt     = page_r[ENTRIES-1];
        out_valid_nxt = 1'b1;
        out_page_nxt  = req_page_r;
        if (hit) begin
          out_action_nxt = lupc_pkg::ACT_HIT;
          out_last_nxt   = 1'b1;
        end else begin
          out_action_nxt = lupc_pkg::ACT_UNPROTECT;
          out_last_nxt   = !valid_r[ENTRIES-1];
        end
      end
      lupc_pkg::DP_EVICT: begin
        out_valid_nxt  = 1'b1;
        out_action_nxt = lupc_pkg::ACT_PROTECT;
        out_page_nxt   = evict_r;
        out_last_nxt   = 1'b1;
      end
      lupc_pkg::DP_FLUSH_STEP: begin
        out_valid_nxt = 1'b1;
        if (valid_r[0]) begin
          for (int j = 0; j < ENTRIES - 1; j++) begin
            page_nxt[j] = page_r[j+1];
          end
          valid_nxt      = {1'b0, valid_r[ENTRIES-1:1]};
          out_action_nxt = lupc_pkg::ACT_PROTECT;
          out_page_nxt   = page_r[0];
          out_last_nxt   = 1'b0;
        end else begin
          out_action_nxt = lupc_pkg::ACT_CLEAR;
          out_page_nxt   = '0;
          out_last_nxt   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r       <= page_nxt;
    req_page_r   <= req_page_nxt;
    evict_r      <= evict_nxt;
    out_action_r <= out_action_nxt;
    out_page_r   <= out_page_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_action      = out_action_r;
  assign out_page_number = out_page_r;
  assign out_last        = out_last_r;

endmodule

[src/lupc_ctrl.sv]
// controller state machine for touch and flush sequencing
module lupc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 in_command,
  input  lupc_pkg::dp_status_t status,
  output lupc_pkg::dp_cmd_t    cmd,
  output logic                 busy
);

  lupc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lupc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.op      = lupc_pkg::DP_NONE;
    busy        = 1'b1;
    unique case (state_r)
      lupc_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = (in_command == lupc_pkg::CMD_FLUSH) ? lupc_pkg::ST_FLUSH
                                                             : lupc_pkg::ST_TOUCH;
        end
      end
      lupc_pkg::ST_TOUCH: begin
        cmd.op    = lupc_pkg::DP_TOUCH;
        state_nxt = (status.hit || !status.full) ? lupc_pkg::ST_IDLE
                                                 : lupc_pkg::ST_EVICT;
      end
      lupc_pkg::ST_EVICT: begin
        cmd.op    = lupc_pkg::DP_EVICT;
        state_nxt = lupc_pkg::ST_IDLE;
      end
      lupc_pkg::ST_FLUSH: begin
        cmd.op = lupc_pkg::DP_FLUSH_STEP;
        if (!status.front_valid) begin
          state_nxt = lupc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lupc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[src/lru_unprotected_page_cache.sv]
// top level of the move-to-front lru cache of writable pages
//
//   channel   ports                                         handshake
//   input     in_command, in_address                        start & !busy
//   result    out_action, out_page_number, out_last         out_valid, one cycle
//
// a touch is accepted, then runs a compare and shift step, and on a miss that evicts
// the last entry an evict step; a flush is accepted, then gives one protect word
// per valid entry and one clear word, set by the list shifting out one entry a cycle.
// each result word sits on the ports for one cycle.
// synchronous reset empties the list; the receiver cannot stall.
module lru_unprotected_page_cache #(
  parameter int ENTRIES    = 10,
  parameter int ADDR_BITS  = 48,
  parameter int PAGE_SHIFT = 12
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_command,
  input  logic [ADDR_BITS-1:0]           in_address,
  output logic                           out_valid,
  output logic [1:0]                     out_action,
  output logic [lupc_pkg::PAGE_BITS-1:0] out_page_number,
  output logic                           out_last
);

  lupc_pkg::dp_cmd_t    cmd;
  lupc_pkg::dp_status_t status;

  lupc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .status     (status),
    .cmd        (cmd),
    .busy       (busy)
  );

  lupc_datapath #(
    .ENTRIES    (ENTRIES),
    .ADDR_BITS  (ADDR_BITS),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_address      (in_address),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (out_valid),
    .out_action      (out_action),
    .out_page_number (out_page_number),
    .out_last        (out_last)
  );

endmodule

[src/lupc_checker.sv]
// port-level assertion checker for the page cache, with its bind
`include "assert_macros.svh"

module lupc_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic                           out_valid,
  input logic [1:0]                     out_action,
  input logic [lupc_pkg::PAGE_BITS-1:0] out_page_number,
  input logic                           out_last
);

  // more words of the same item still to come
  `ASSERT_IMPL(a_pending_busy, clk, rst_n, out_valid && !out_last, busy, "idle with words pending")
  `ASSERT_NEXT(a_accept_quiet, clk, rst_n, start && !busy, busy && !out_valid, "bad accept follow-up")
  `ASSERT_IMPL(a_hit_last, clk, rst_n, out_valid && (out_action == lupc_pkg::ACT_HIT), out_last, "hit word not last")
  `ASSERT_IMPL(a_clear_form, clk, rst_n, out_valid && (out_action == lupc_pkg::ACT_CLEAR), out_last && (out_page_number == '0), "bad clear word")

endmodule

bind lru_unprotected_page_cache lupc_checker u_lupc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_action      (out_action),
  .out_page_number (out_page_number),
  .out_last        (out_last)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps
// self-checking testbench for the move-to-front lru cache of writable pages
module tb_top;

  localparam int ENTRIES     = 10;
  localparam int ADDR_W      = 48;
  localparam int PG_SHIFT    = 12;
  localparam int PAGE_W      = lupc_pkg::PAGE_BITS;
  localparam int RAND_WORDS  = 350;
  localparam int STALL_LIMIT = 2000;
  localparam int POOL_SIZE   = 16;

  typedef struct packed {
    lupc_pkg::action_t action;
    logic [PAGE_W-1:0] page;
    logic              last;
  } page_word_t;

  typedef struct packed {
    logic              cmd;
    logic [ADDR_W-1:0] addr;
    logic              typed;
    page_word_t        want;
  } stim_row_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_command;
  logic [ADDR_W-1:0] in_address;
  logic              out_valid;
  logic [1:0]        out_action;
  logic [PAGE_W-1:0] out_page_number;
  logic              out_last;

  lru_unprotected_page_cache #(
    .ENTRIES(ENTRIES),
    .ADDR_BITS(ADDR_W),
    .PAGE_SHIFT(PG_SHIFT)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_command(in_command),
    .in_address(in_address),
    .out_valid(out_valid),
    .out_action(out_action),
    .out_page_number(out_page_number),
    .out_last(out_last)
  );

  // predictor state, index 0 is the hottest page
  logic [PAGE_W-1:0] hot_pages [0:ENTRIES-1];
  logic              page_live [0:ENTRIES-1];
  page_word_t        step_words [0:ENTRIES];
  page_word_t        pending_words [$];
  page_word_t        seen_want;

  int fail_count;
  int hit_count;
  int miss_count;
  int evict_count;
  int flush_count;
  int words_checked;
  int stall_cycles;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (fail_count < 20) begin
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    end
    fail_count++;
  endtask

  function automatic stim_row_t stim_row(input logic cmd, input logic [ADDR_W-1:0] addr,
                                         input logic typed, input lupc_pkg::action_t act,
                                         input logic [PAGE_W-1:0] pg);
    stim_row_t row;
    row.cmd         = cmd;
    row.addr        = addr;
    row.typed       = typed;
    row.want.action = act;
    row.want.page   = pg;
    row.want.last   = 1'b1;
    return row;
  endfunction

  task automatic predict_lru(input logic cmd, input logic [ADDR_W-1:0] addr, output int n);
    logic [PAGE_W-1:0] pg;
    int hit_at;
    n = 0;
    hit_at = -1;
    if (cmd == lupc_pkg::CMD_FLUSH) begin
      flush_count++;
      for (int i = 0; i < ENTRIES; i++) begin
        if (page_live[i]) begin
          step_words[n].action = lupc_pkg::ACT_PROTECT;
          step_words[n].page   = hot_pages[i];
          step_words[n].last   = 1'b0;
          n++;
        end
      end
      step_words[n].action = lupc_pkg::ACT_CLEAR;
      step_words[n].page   = '0;
      step_words[n].last   = 1'b1;
      n++;
      for (int i = 0; i < ENTRIES; i++) begin
        hot_pages[i] = '0;
        page_live[i] = 1'b0;
      end
    end else begin
      pg = addr[PG_SHIFT +: PAGE_W];
      for (int i = ENTRIES - 1; i >= 0; i--) begin
        if (page_live[i] && hot_pages[i] == pg) hit_at = i;
      end
      if (hit_at >= 0) begin
        hit_count++;
        for (int j = hit_at; j > 0; j--) begin
          hot_pages[j] = hot_pages[j-1];
          page_live[j] = page_live[j-1];
        end
        step_words[0].action = lupc_pkg::ACT_HIT;
        step_words[0].page   = pg;
        step_words[0].last   = 1'b1;
        n = 1;
      end else begin
        miss_count++;
        step_words[0].action = lupc_pkg::ACT_UNPROTECT;
        step_words[0].page   = pg;
        if (page_live[ENTRIES-1]) begin
          evict_count++;
          step_words[0].last   = 1'b0;
          step_words[1].action = lupc_pkg::ACT_PROTECT;
          step_words[1].page   = hot_pages[ENTRIES-1];
          step_words[1].last   = 1'b1;
          n = 2;
        end else begin
          step_words[0].last = 1'b1;
          n = 1;
        end
        for (int j = ENTRIES - 1; j > 0; j--) begin
          hot_pages[j] = hot_pages[j-1];
          page_live[j] = page_live[j-1];
        end
      end
      hot_pages[0] = pg;
      page_live[0] = 1'b1;
    end
  endtask

  // drive one command word, wait for it to be taken, then queue what it must produce
  task automatic issue_word(input stim_row_t row, input bit may_idle);
    int n;
    @(negedge clk);
    while (may_idle && $urandom_range(99) < 30) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start      <= 1'b1;
    in_command <= row.cmd;
    in_address <= row.addr;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_lru(row.cmd, row.addr, n);
    if (row.typed) begin
      pending_words.push_back(row.want);
    end else begin
      for (int i = 0; i < n; i++) pending_words.push_back(step_words[i]);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word, action", 64'(out_action), 64'd0);
      end else begin
        seen_want = pending_words.pop_front();
        words_checked++;
        if (out_action != seen_want.action)
          report_mismatch("action", 64'(out_action), 64'(seen_want.action));
        if (out_page_number != seen_want.page)
          report_mismatch("page_number", 64'(out_page_number), 64'(seen_want.page));
        if (out_last != seen_want.last)
          report_mismatch("last", 64'(out_last), 64'(seen_want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: nothing moved for %0d cycles", STALL_LIMIT);
      $display("tb_top NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    stim_row_t         rows [$];
    stim_row_t         row;
    logic [PAGE_W-1:0] page_pool [0:POOL_SIZE-1];
    logic [11:0]       offs;
    int                r;
    bit                may_idle;

    rst_n        = 1'b0;
    start        = 1'b0;
    in_command   = lupc_pkg::CMD_TOUCH;
    in_address   = '0;
    hit_count    = 0;
    miss_count   = 0;
    evict_count  = 0;
    flush_count  = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      hot_pages[i] = '0;
      page_live[i] = 1'b0;
    end
    page_pool[0] = '0;
    page_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) page_pool[i] = PAGE_W'({$urandom, $urandom});

    rows.push_back(stim_row(lupc_pkg::CMD_FLUSH, 48'h0, 1'b1, lupc_pkg::ACT_CLEAR, 36'h0));
    rows.push_back(stim_row(lupc_pkg::CMD_TOUCH, 48'h0, 1'b1, lupc_pkg::ACT_UNPROTECT,
                            36'h0));
    rows.push_back(stim_row(lupc_pkg::CMD_TOUCH, 48'h0000_0000_0fff, 1'b1,
                            lupc_pkg::ACT_HIT, 36'h0));
    rows.push_back(stim_row(lupc_pkg::CMD_TOUCH, 48'hffff_ffff_ffff, 1'b1,
                            lupc_pkg::ACT_UNPROTECT, 36'hf_ffff_ffff));
    rows.push_back(stim_row(lupc_pkg::CMD_TOUCH, 48'hffff_ffff_f000, 1'b1,
                            lupc_pkg::ACT_HIT, 36'hf_ffff_ffff));
    for (int i = 1; i <= 8; i++) begin
      rows.push_back(stim_row(lupc_pkg::CMD_TOUCH, (48'(i) << PG_SHIFT) | 48'(i * 37), 1'b0,
                              lupc_pkg::ACT_HIT, '0));
    end
    // page zero now sits at the cold end of a full list
    rows.push_back(stim_row(lupc_pkg::CMD_TOUCH, 48'h0000_0000_0123, 1'b0,
                            lupc_pkg::ACT_HIT, '0));
    rows.push_back(stim_row(lupc_pkg::CMD_TOUCH, 48'h0000_0000_9abc, 1'b0,
                            lupc_pkg::ACT_HIT, '0));
    rows.push_back(stim_row(lupc_pkg::CMD_TOUCH, 48'h5555_5555_5555, 1'b0,
                            lupc_pkg::ACT_HIT, '0));
    rows.push_back(stim_row(lupc_pkg::CMD_TOUCH, 48'haaaa_aaaa_aaaa, 1'b0,
                            lupc_pkg::ACT_HIT, '0));
    rows.push_back(stim_row(lupc_pkg::CMD_TOUCH, 48'h0000_0000_8000, 1'b0,
                            lupc_pkg::ACT_HIT, '0));
    rows.push_back(stim_row(lupc_pkg::CMD_FLUSH, 48'hffff_ffff_ffff, 1'b0,
                            lupc_pkg::ACT_HIT, '0));
    rows.push_back(stim_row(lupc_pkg::CMD_FLUSH, 48'h1234_5678_9abc, 1'b1,
                            lupc_pkg::ACT_CLEAR, 36'h0));
    rows.push_back(stim_row(lupc_pkg::CMD_TOUCH, 48'h0000_0000_1000, 1'b1,
                            lupc_pkg::ACT_UNPROTECT, 36'h1));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[k]) issue_word(rows[k], 1'b1);

    for (int k = 0; k < RAND_WORDS; k++) begin
      if (k == 60 || k == 250) begin
        @(negedge clk);
        start <= 1'b0;
        while (pending_words.size() != 0) @(negedge clk);
      end
      r = $urandom_range(99);
      offs = 12'($urandom);
      row = stim_row(lupc_pkg::CMD_TOUCH, ADDR_W'({$urandom, $urandom}), 1'b0,
                     lupc_pkg::ACT_HIT, '0);
      if (r < 6) begin
        row.cmd = lupc_pkg::CMD_FLUSH;
      end else if (r < 80) begin
        row.addr = {page_pool[$urandom_range(POOL_SIZE-1)], offs};
      end
      may_idle = !(k >= 120 && k < 200);
      issue_word(row, may_idle);
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d command words: %0d hits, %0d misses (%0d evicting), %0d flushes",
             rows.size() + RAND_WORDS, hit_count, miss_count, evict_count, flush_count);
    $display("checked %0d result words, %0d mismatches", words_checked, fail_count);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

[lru_unprotected_page_cache.f]
+incdir+src
src/lupc_pkg.sv
src/lupc_datapath.sv
src/lupc_ctrl.sv
src/lru_unprotected_page_cache.sv
src/lupc_checker.sv
tb/tb_top.sv
